### rtl/first_fit_segment_allocator_unit_defines.svh
// assertion macros for the first-fit segment allocator checker
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// concurrent assertion clocked on clk_i, off while reset is held
`define FFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, for a property that must hold through reset too
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/ffsa_pkg.sv
// shared constants, codes and controller/datapath interface types
`default_nettype none

package ffsa_pkg;

  localparam int unsigned MAX_SEGS_DEF   = 32;
  localparam int unsigned ADDR_BITS_DEF  = 16;
  localparam int unsigned OWNER_BITS_DEF = 8;
  localparam int unsigned TOTAL_SIZE_RST = 65535;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_HOLE   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_scan;
    logic rd_shift;
    logic scan_next;
    logic set_nohole;
    logic set_full;
    logic set_release;
    logic wr_exact;
    logic wr_release;
    logic start_split;
    logic wr_shift;
    logic wr_insert;
    logic wr_alloc;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_release;
    logic want_zero;
    logic idx_end;
    logic fits;
    logic exact;
    logic full;
    logic own_match;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/ffsa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ffsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/ffsa_ctrl.sv
// controller state machine: scan, split shift, insert and result hand-off
`default_nettype none

module ffsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ffsa_pkg::sts_t sts_i,
  output ffsa_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_INS  = 3'd5;
  localparam logic [2:0] S_ALW  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        if (!sts_i.is_release && sts_i.want_zero) begin
          cmd_o.set_nohole = 1'b1;
          state_d          = S_FIN;
        end else if (sts_i.idx_end) begin
          if (sts_i.is_release) begin
            cmd_o.set_release = 1'b1;
          end else begin
            cmd_o.set_nohole = 1'b1;
          end
          state_d = S_FIN;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_EV;
        end
      end
      S_EV: begin
        if (sts_i.is_release) begin
          cmd_o.wr_release = sts_i.own_match;
          cmd_o.scan_next  = 1'b1;
          state_d          = S_RD;
        end else if (sts_i.fits) begin
          if (sts_i.exact) begin
            cmd_o.wr_exact = 1'b1;
            state_d        = S_FIN;
          end else if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_FIN;
          end else begin
            cmd_o.start_split = 1'b1;
            state_d           = S_SHRD;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_RD;
        end
      end
      S_SHRD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_shift = 1'b1;
          state_d        = S_SHWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SHRD;
      end
      S_INS: begin
        cmd_o.wr_insert = 1'b1;
        state_d         = S_ALW;
      end
      S_ALW: begin
        cmd_o.wr_alloc = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ffsa_dpath.sv
// datapath: segment table ram, counters, request and result registers
`default_nettype none

module ffsa_dpath #(
  parameter int unsigned MAX_SEGS   = ffsa_pkg::MAX_SEGS_DEF,
  parameter int unsigned ADDR_BITS  = ffsa_pkg::ADDR_BITS_DEF,
  parameter int unsigned OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [ADDR_BITS-1:0]  cfg_wdata_i,
  input  wire logic                  kind_i,
  input  wire logic [ADDR_BITS-1:0]  request_size_i,
  input  wire logic [OWNER_BITS-1:0] owner_id_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [ADDR_BITS-1:0]       start_offset_o,
  input  wire ffsa_pkg::cmd_t        cmd_i,
  output ffsa_pkg::sts_t             sts_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SEGS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SEGS);
  localparam int unsigned ENT_W = 2 * ADDR_BITS + OWNER_BITS + 1;

  logic [ADDR_BITS-1:0]  total_q;
  logic [CNT_W-1:0]      cnt_q, idx_q, j_q, fidx_q;
  logic                  e0_q, rd0_q, found_q;
  logic                  kind_q;
  logic [ADDR_BITS-1:0]  want_q, fstart_q, fsize_q, res_start_q;
  logic [OWNER_BITS-1:0] own_q;
  logic [1:0]            res_status_q;
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [ADDR_BITS-1:0]  out_start_q;

  logic [ENT_W-1:0]      ram_rdata, ent, wdata;
  logic [ADDR_BITS-1:0]  ent_start, ent_size;
  logic [OWNER_BITS-1:0] ent_owner;
  logic                  ent_used;
  logic                  re, we;
  logic [IDX_W-1:0]      raddr, waddr;
  logic [CNT_W-1:0]      jm1, fidx_p1;

  assign jm1     = j_q - CNT_W'(1);
  assign fidx_p1 = fidx_q + CNT_W'(1);

  // entry 0 reads as the initial free segment until first written
  assign ent = (rd0_q && e0_q) ? {{ADDR_BITS{1'b0}}, total_q, {OWNER_BITS{1'b0}}, 1'b0}
                               : ram_rdata;
  assign ent_used  = ent[0];
  assign ent_owner = ent[OWNER_BITS:1];
  assign ent_size  = ent[OWNER_BITS+ADDR_BITS:OWNER_BITS+1];
  assign ent_start = ent[ENT_W-1:OWNER_BITS+ADDR_BITS+1];

  assign re    = cmd_i.rd_scan | cmd_i.rd_shift;
  assign raddr = cmd_i.rd_shift ? jm1[IDX_W-1:0] : idx_q[IDX_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IDX_W-1:0];
    wdata = ent;
    if (cmd_i.wr_exact) begin
      we    = 1'b1;
      wdata = {ent_start, ent_size, own_q, 1'b1};
    end else if (cmd_i.wr_release) begin
      we    = 1'b1;
      wdata = {ent_start, ent_size, ent_owner, 1'b0};
    end else if (cmd_i.wr_shift) begin
      we    = 1'b1;
      waddr = j_q[IDX_W-1:0];
      wdata = ent;
    end else if (cmd_i.wr_insert) begin
      we    = 1'b1;
      waddr = fidx_p1[IDX_W-1:0];
      wdata = {fstart_q + want_q, fsize_q - want_q, {OWNER_BITS{1'b0}}, 1'b0};
    end else if (cmd_i.wr_alloc) begin
      we    = 1'b1;
      waddr = fidx_q[IDX_W-1:0];
      wdata = {fstart_q, want_q, own_q, 1'b1};
    end
  end

  ffsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SEGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // table bookkeeping and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= ADDR_BITS'(ffsa_pkg::TOTAL_SIZE_RST);
      cnt_q       <= CNT_W'(1);
      e0_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        cnt_q   <= CNT_W'(1);
        e0_q    <= 1'b1;
      end else begin
        if (we && (waddr == '0)) begin
          e0_q <= 1'b0;
        end
        if (cmd_i.wr_alloc) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      want_q  <= request_size_i;
      own_q   <= owner_id_i;
      idx_q   <= '0;
      found_q <= 1'b0;
    end
    if (re) begin
      rd0_q <= (raddr == '0);
    end
    if (cmd_i.scan_next) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    if (cmd_i.wr_release) begin
      found_q <= 1'b1;
    end
    if (cmd_i.start_split) begin
      fidx_q   <= idx_q;
      fstart_q <= ent_start;
      fsize_q  <= ent_size;
      j_q      <= cnt_q;
    end
    if (cmd_i.wr_shift) begin
      j_q <= jm1;
    end
    if (cmd_i.set_nohole) begin
      res_status_q <= ffsa_pkg::ST_NO_HOLE;
      res_start_q  <= '0;
    end
    if (cmd_i.set_full) begin
      res_status_q <= ffsa_pkg::ST_FULL;
      res_start_q  <= '0;
    end
    if (cmd_i.set_release) begin
      res_status_q <= found_q ? ffsa_pkg::ST_OK : ffsa_pkg::ST_NOT_FOUND;
      res_start_q  <= '0;
    end
    if (cmd_i.wr_exact) begin
      res_status_q <= ffsa_pkg::ST_OK;
      res_start_q  <= ent_start;
    end
    if (cmd_i.wr_alloc) begin
      res_status_q <= ffsa_pkg::ST_OK;
      res_start_q  <= fstart_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
    end
  end

  assign sts_o.is_release = (kind_q == ffsa_pkg::KIND_RELEASE);
  assign sts_o.want_zero  = (want_q == '0);
  assign sts_o.idx_end    = (idx_q >= cnt_q);
  assign sts_o.fits       = !ent_used && (ent_size >= want_q);
  assign sts_o.exact      = (ent_size == want_q);
  assign sts_o.full       = (cnt_q == CNT_W'(MAX_SEGS));
  assign sts_o.own_match  = ent_used && (ent_owner == own_q);
  assign sts_o.shift_more = (j_q > fidx_p1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign start_offset_o = out_start_q;

endmodule

`default_nettype wire

### rtl/first_fit_segment_allocator_unit.sv
// top level of the first-fit segment allocator
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    kind_i, request_size_i, owner_id_i
//  out       output     out_valid_o / out_ready_i  status_o, start_offset_o
//  cfg       input      cfg_we_i (no wait)         cfg_wdata_i (memory size)
//
//  one item at a time: the table sits in a single ram with one read and one
//  write port and registered read, so each scanned entry takes a read state
//  and an evaluate state; a release scans every entry, and an allocate that
//  splits scans up to the hit and moves every entry above it up by one
//  reset and a memory size write take effect at once: no clearing pass, the
//  fill count bounds the table and entry 0 reads as the initial segment
//  a result waits in the output register; a stalled output only holds the
//  block in its final state
`default_nettype none

module first_fit_segment_allocator_unit #(
  parameter int unsigned MAX_SEGS   = ffsa_pkg::MAX_SEGS_DEF,
  parameter int unsigned ADDR_BITS  = ffsa_pkg::ADDR_BITS_DEF,
  parameter int unsigned OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [ADDR_BITS-1:0]  cfg_wdata_i,
  // request transfer
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  kind_i,
  input  wire logic [ADDR_BITS-1:0]  request_size_i,
  input  wire logic [OWNER_BITS-1:0] owner_id_i,
  // result transfer
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [ADDR_BITS-1:0]       start_offset_o
);

  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::sts_t sts;

  // sequencing: accept, scan, shift for a split, insert remainder, hand off
  ffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // segment table, fill count and result registers
  ffsa_dpath #(
    .MAX_SEGS   (MAX_SEGS),
    .ADDR_BITS  (ADDR_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .owner_id_i     (owner_id_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .start_offset_o (start_offset_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

### rtl/ffsa_chk.sv
// port-level checker for the allocator, bound to the top level
`default_nettype none
`include "first_fit_segment_allocator_unit_defines.svh"

module ffsa_chk #(
  parameter int unsigned ADDR_BITS = ffsa_pkg::ADDR_BITS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [1:0]           status_o,
  input wire logic [ADDR_BITS-1:0] start_offset_o
);

  // one request in flight: ready drops straight after a transfer
  `FFSA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

  // only a successful allocate carries a start offset
  `FFSA_ASSERT(a_start_zero, (out_valid_o && (status_o != ffsa_pkg::ST_OK)) |-> (start_offset_o == '0), "offset on failure")

  // a result appears only while no request could be taken
  `FFSA_ASSERT(a_result_busy, $rose(out_valid_o) |-> !$past(in_ready_o), "result while idle")

  // a stalled result holds
  `FFSA_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) && $stable(start_offset_o)), "result changed under stall")

endmodule

bind first_fit_segment_allocator_unit ffsa_chk #(
  .ADDR_BITS (ADDR_BITS)
) u_ffsa_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .start_offset_o (start_offset_o)
);

`default_nettype wire
